/* hdl/rde_pkg.sv */
// Shared types and constants for the radix digit emitter.
// No dependencies; every other file in hdl/ imports this package.

package rde_pkg;

    localparam int VALUE_W     = 64;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int BITS_PER_CYC = 8;
    localparam int DIV_CYCLES  = VALUE_W / BITS_PER_CYC;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0]  RADIX_RESET      = 5'd10;
    localparam logic [VALUE_W-1:0]  CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [VALUE_W-1:0]  CHARS_HIGH_RESET = 64'h6665_6463_6261_3938;
    localparam logic [RADIX_W-1:0]  RADIX_MIN        = 5'd2;

    typedef struct packed {
        logic                 start;
        logic [RADIX_W-1:0]   radix;
        logic [VALUE_W-1:0]   dividend;
    } div_ctrl_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [VALUE_W-1:0]   quotient;
        logic [DIGIT_W-1:0]   remainder;
    } div_sts_t;

    // Map a digit to its character through the 16-entry byte table
    function automatic logic [CHAR_W-1:0] digit_to_char(
        input logic [DIGIT_W-1:0] digit,
        input logic [VALUE_W-1:0] chars_low,
        input logic [VALUE_W-1:0] chars_high
    );
        logic [2*VALUE_W-1:0] tbl;
        tbl = {chars_high, chars_low};
        return tbl[{digit, 3'b000} +: CHAR_W];
    endfunction

endpackage

/* hdl/rde_ifs.sv */
// Valid/ready channel interfaces for the radix digit emitter.
// Depends on rde_pkg for field widths.

interface rde_in_if import rde_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               is_signed;

    modport source (output valid, value, is_signed, input ready);
    modport sink   (input valid, value, is_signed, output ready);
endinterface

interface rde_out_if import rde_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  digit_char;
    logic               minus_first;
    logic               last;
    logic [COUNT_W-1:0] char_count;

    modport source (output valid, digit_char, minus_first, last, char_count, input ready);
    modport sink   (input valid, digit_char, minus_first, last, char_count, output ready);
endinterface

interface rde_cfg_if import rde_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VALUE_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/rde_div_unit.sv */
// Iterative divider: 64-bit dividend by a radix of 2..16, eight quotient bits a cycle.
// Depends on rde_pkg for widths and the control/status structs.

module rde_div_unit
    import rde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_ctrl_t ctrl,
    output div_sts_t  sts
);

    logic [VALUE_W-1:0]   work_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [VALUE_W-1:0]   work_next;
    logic [DIGIT_W-1:0]   rem_next;

    // Shift dividend bits out the top, quotient bits in the bottom
    always_comb
    begin
        logic [DIGIT_W:0]   trial;
        logic [VALUE_W-1:0] w;
        logic [DIGIT_W-1:0] r;
        w = work_reg;
        r = rem_reg;
        for (int i = 0; i < BITS_PER_CYC; i++)
        begin
            trial = {r, w[VALUE_W-1]};
            w     = {w[VALUE_W-2:0], 1'b0};
            if (trial >= ctrl.radix)
            begin
                trial = trial - ctrl.radix;
                w[0]  = 1'b1;
            end
            r = trial[DIGIT_W-1:0];
        end
        work_next = w;
        rem_next  = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
        else if (ctrl.start)
        begin
            work_reg <= ctrl.dividend;
            rem_reg  <= '0;
        end
    end

    assign sts.busy      = busy_reg;
    assign sts.done      = done_reg;
    assign sts.quotient  = work_reg;
    assign sts.remainder = rem_reg;

endmodule

/* hdl/radix_digit_emitter_unit.sv */
// Top level of the radix digit emitter: sequencer, digit store and output register.
// Depends on rde_pkg, rde_ifs (channel interfaces) and rde_div_unit.
//
// Usage:
//   din  carries one 64-bit value and is_signed per transaction. The block
//        takes one number at a time; din.ready is high only while idle.
//   dout carries one character per transaction, most significant digit first.
//        minus_first marks the first character of a negative signed number,
//        last marks the final one, which also carries the total character
//        count including the sign.
//   cfg  writes radix (index 0) and the digit character table (1 and 2). It is
//        always ready; write it only while no number is in flight.
// Sequence: each digit costs one pass of the shared divider (start, divide
//   steps of eight quotient bits each, write-back). Emission then reads the
//   digit store and loads the output register for each character.
// Reset clears the sequencer, the output valid and the registers to radix 10
//   and the table "0123456789abcdef". A stalled dout holds the current
//   character in the output register; the sequencer waits until it is taken.

module radix_digit_emitter_unit
    import rde_pkg::*;
#(
    parameter int MAX_DIGITS = 64,
    parameter int MAX_RADIX  = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    rde_in_if.sink       din,
    rde_out_if.source    dout,
    rde_cfg_if.sink      cfg
);

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t                state_reg;
    logic [RADIX_W-1:0]    radix_reg;
    logic [VALUE_W-1:0]    chars_low_reg;
    logic [VALUE_W-1:0]    chars_high_reg;
    logic [VALUE_W-1:0]    quot_reg;
    logic                  neg_reg;
    logic                  first_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [ADDR_W-1:0]     pos_reg;
    logic [COUNT_W-1:0]    total_reg;
    logic [DIGIT_W-1:0]    rdata_reg;
    logic [DIGIT_W-1:0]    digit_mem [MAX_DIGITS];

    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic                  out_minus_reg;
    logic                  out_last_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    logic [RADIX_W-1:0]    radix_eff;
    logic                  in_neg;
    logic                  mem_we;
    logic                  mem_re;
    logic                  out_free;
    div_ctrl_t             div_ctrl;
    div_sts_t              div_sts;

    // Clamp radix into 2..MAX_RADIX
    always_comb
    begin
        radix_eff = radix_reg;
        if (radix_eff < RADIX_MIN)
            radix_eff = RADIX_MIN;
        if (radix_eff > RADIX_W'(MAX_RADIX))
            radix_eff = RADIX_W'(MAX_RADIX);
    end

    assign in_neg   = din.is_signed & din.value[VALUE_W-1];
    assign mem_we   = (state_reg == ST_WAIT) && div_sts.done;
    assign mem_re   = (state_reg == ST_READ);
    assign out_free = !out_valid_reg || dout.ready;

    assign div_ctrl.start    = (state_reg == ST_START);
    assign div_ctrl.radix    = radix_eff;
    assign div_ctrl.dividend = quot_reg;

    rde_div_unit u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .sts   (div_sts)
    );

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RADIX_RESET;
            chars_low_reg  <= CHARS_LOW_RESET;
            chars_high_reg <= CHARS_HIGH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_RADIX:      radix_reg      <= cfg.data[RADIX_W-1:0];
                CFG_CHARS_LOW:  chars_low_reg  <= cfg.data;
                CFG_CHARS_HIGH: chars_high_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // Digit store, least significant digit at address 0
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[cnt_reg[ADDR_W-1:0]] <= div_sts.remainder;
        if (mem_re)
            rdata_reg <= digit_mem[pos_reg];
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_minus_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_count_reg <= '0;
            cnt_reg       <= '0;
            quot_reg      <= '0;
            neg_reg       <= 1'b0;
            first_reg     <= 1'b0;
            pos_reg       <= '0;
            total_reg     <= '0;
        end
        else
        begin
            // ST_LOAD drives the output valid on its own
            if (out_valid_reg && dout.ready && state_reg != ST_LOAD)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (din.valid)
                    begin
                        quot_reg  <= in_neg ? (VALUE_W'(0) - din.value) : din.value;
                        neg_reg   <= in_neg;
                        cnt_reg   <= '0;
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (div_sts.done)
                    begin
                        quot_reg <= div_sts.quotient;
                        cnt_reg  <= cnt_reg + 1'b1;
                        if (div_sts.quotient != '0 &&
                            cnt_reg != CNT_W'(MAX_DIGITS - 1))
                            state_reg <= ST_START;
                        else
                        begin
                            pos_reg   <= cnt_reg[ADDR_W-1:0];
                            total_reg <= COUNT_W'(cnt_reg) + COUNT_W'(1)
                                         + COUNT_W'(neg_reg);
                            first_reg <= 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                    state_reg <= ST_LOAD;
                ST_LOAD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= digit_to_char(rdata_reg, chars_low_reg,
                                                       chars_high_reg);
                        out_minus_reg <= first_reg & neg_reg;
                        out_last_reg  <= (pos_reg == '0);
                        out_count_reg <= (pos_reg == '0) ? total_reg : '0;
                        first_reg     <= 1'b0;
                        if (pos_reg == '0)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            pos_reg   <= pos_reg - 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign din.ready        = (state_reg == ST_IDLE);
    assign dout.valid       = out_valid_reg;
    assign dout.digit_char  = out_char_reg;
    assign dout.minus_first = out_minus_reg;
    assign dout.last        = out_last_reg;
    assign dout.char_count  = out_count_reg;

    // The divider reports completion only while the sequencer waits for it
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> state_reg == ST_WAIT)
        else $error("divider done outside wait state");

    // The divider is started only while it is idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_sts.busy)
        else $error("divider started while busy");

    // Digit count never exceeds the store depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    // The final character always carries a nonzero count
    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.last) |-> dout.char_count != '0)
        else $error("last character without count");

    // A one-digit negative number counts the sign as well
    a_minus_single: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.minus_first && dout.last) |-> dout.char_count == COUNT_W'(2))
        else $error("sign not counted on single-digit number");

endmodule
